>>> src/grid_six_neighbour_index_unit_assert.svh
// assertion macros used by the checker file
`ifndef GRID_SIX_NEIGHBOUR_INDEX_UNIT_ASSERT_SVH
`define GRID_SIX_NEIGHBOUR_INDEX_UNIT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define GSNI_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// plain condition checked every cycle out of reset
`define GSNI_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

`endif

>>> src/gsni_pkg.sv
package gsni_pkg;

    localparam int MAX_DIM         = 1024;
    localparam int SIZE_W          = 11;
    localparam int IDX_W           = 31;
    localparam int XY_W            = 2 * SIZE_W;
    localparam int DQ_W            = IDX_W + 1;
    localparam int STEPS_PER_STAGE = 4;
    localparam int DIV_STAGES      = DQ_W / STEPS_PER_STAGE;
    localparam int NUM_STAGES      = 2 * DIV_STAGES;
    localparam int PIPE_LAT        = NUM_STAGES + 2;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = 2'd3;

    typedef struct packed {
        logic [SIZE_W-1:0] rem;
        logic [DQ_W-1:0]   dq;
    } t_div_st;

    typedef struct packed {
        logic              err;
        logic [IDX_W-1:0]  idx;
        t_div_st           div;
        logic [SIZE_W-1:0] px0;
    } t_stage;

    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
        logic [SIZE_W-1:0] r;
        r = s;
        if (s == '0) begin
            r = SIZE_W'(1);
        end else if (s > SIZE_W'(MAX_DIM)) begin
            r = SIZE_W'(MAX_DIM);
        end
        return r;
    endfunction

    // restoring division, one quotient bit per step
    function automatic t_div_st div_steps(input t_div_st s, input logic [SIZE_W-1:0] d);
        t_div_st       r;
        logic [SIZE_W:0] t;
        logic          qb;
        r = s;
        for (int i = 0; i < STEPS_PER_STAGE; i++) begin
            t  = {r.rem, r.dq[DQ_W-1]};
            qb = (t >= {1'b0, d});
            if (qb) begin
                t = t - {1'b0, d};
            end
            r.rem = t[SIZE_W-1:0];
            r.dq  = {r.dq[DQ_W-2:0], qb};
        end
        return r;
    endfunction

endpackage

>>> src/grid_six_neighbour_index_unit.sv
// pipeline: an input register, the divider stages and an output register
// throughput: one request per cycle, busy stays low once out of reset
// the divider stages form two chained 32-step restoring dividers, four steps per stage
// reset: synchronous, sizes and point count go to 1, pipeline emptied,
// busy high during reset and the cycle after; the receiver cannot stall
module grid_six_neighbour_index_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [gsni_pkg::IDX_W-1:0]          i_point_index,
    input  logic                                i_cfg_we,
    input  logic [gsni_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [gsni_pkg::IDX_W-1:0]          i_cfg_data,
    output logic                                o_valid,
    output logic [gsni_pkg::IDX_W-1:0]          o_neighbour_x_minus,
    output logic [gsni_pkg::IDX_W-1:0]          o_neighbour_x_plus,
    output logic [gsni_pkg::IDX_W-1:0]          o_neighbour_y_minus,
    output logic [gsni_pkg::IDX_W-1:0]          o_neighbour_y_plus,
    output logic [gsni_pkg::IDX_W-1:0]          o_neighbour_z_minus,
    output logic [gsni_pkg::IDX_W-1:0]          o_neighbour_z_plus,
    output logic                                o_index_error
);

    logic [gsni_pkg::SIZE_W-1:0] r_size_x;
    logic [gsni_pkg::SIZE_W-1:0] r_size_y;
    logic [gsni_pkg::SIZE_W-1:0] r_size_z;
    logic [gsni_pkg::IDX_W-1:0]  r_point_count;
    logic [gsni_pkg::XY_W-1:0]   r_size_xy;
    logic                        r_run;
    logic                        accept;

    logic [gsni_pkg::NUM_STAGES:0] r_vld;
    logic [gsni_pkg::NUM_STAGES:0] n_vld;
    gsni_pkg::t_stage              r_stg [gsni_pkg::NUM_STAGES+1];
    gsni_pkg::t_stage              n_stg [gsni_pkg::NUM_STAGES+1];

    logic                       r_out_valid;
    logic                       r_out_err;
    logic [gsni_pkg::IDX_W-1:0] r_out_xm, r_out_xp, r_out_ym, r_out_yp, r_out_zm, r_out_zp;
    logic [gsni_pkg::IDX_W-1:0] n_out_xm, n_out_xp, n_out_ym, n_out_yp, n_out_zm, n_out_zp;

    assign busy   = !r_run;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run         <= 1'b0;
            r_size_x      <= gsni_pkg::SIZE_W'(1);
            r_size_y      <= gsni_pkg::SIZE_W'(1);
            r_size_z      <= gsni_pkg::SIZE_W'(1);
            r_point_count <= gsni_pkg::IDX_W'(1);
        end else begin
            r_run <= 1'b1;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    gsni_pkg::CFG_SIZE_X: begin
                        r_size_x <= gsni_pkg::eff_size(i_cfg_data[gsni_pkg::SIZE_W-1:0]);
                    end
                    gsni_pkg::CFG_SIZE_Y: begin
                        r_size_y <= gsni_pkg::eff_size(i_cfg_data[gsni_pkg::SIZE_W-1:0]);
                    end
                    gsni_pkg::CFG_SIZE_Z: begin
                        r_size_z <= gsni_pkg::eff_size(i_cfg_data[gsni_pkg::SIZE_W-1:0]);
                    end
                    gsni_pkg::CFG_POINT_COUNT: begin
                        r_point_count <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // layer size, settles long before any request reaches the last stage
    always_ff @(posedge i_clk) begin
        r_size_xy <= gsni_pkg::XY_W'(r_size_x) * gsni_pkg::XY_W'(r_size_y);
    end

    // stage 0 loads the request, stages 1..8 divide by size_x, 9..16 the quotient by size_y
    always_comb begin
        gsni_pkg::t_div_st src;
        src = '0;
        n_vld[0]          = accept;
        n_stg[0].err      = (i_point_index == '0) || (i_point_index > r_point_count);
        n_stg[0].idx      = i_point_index;
        n_stg[0].div.rem  = '0;
        n_stg[0].div.dq   = {1'b0, i_point_index - gsni_pkg::IDX_W'(1)};
        n_stg[0].px0      = '0;
        for (int s = 1; s <= gsni_pkg::NUM_STAGES; s++) begin
            n_vld[s] = r_vld[s-1];
            n_stg[s] = r_stg[s-1];
            src      = r_stg[s-1].div;
            if (s == gsni_pkg::DIV_STAGES + 1) begin
                n_stg[s].px0 = r_stg[s-1].div.rem;
                src.rem      = '0;
            end
            if (s <= gsni_pkg::DIV_STAGES) begin
                n_stg[s].div = gsni_pkg::div_steps(src, r_size_x);
            end else begin
                n_stg[s].div = gsni_pkg::div_steps(src, r_size_y);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_stg <= n_stg;
    end

    // neighbour formation from the zero-based coordinates
    always_comb begin
        gsni_pkg::t_stage           last;
        logic [gsni_pkg::IDX_W-1:0] sx;
        logic [gsni_pkg::IDX_W-1:0] sxy;
        logic [gsni_pkg::SIZE_W-1:0] py0;
        logic [gsni_pkg::DQ_W-1:0]  pz0;
        last = r_stg[gsni_pkg::NUM_STAGES];
        sx   = gsni_pkg::IDX_W'(r_size_x);
        sxy  = gsni_pkg::IDX_W'(r_size_xy);
        py0  = last.div.rem;
        pz0  = last.div.dq;
        n_out_xm = (last.px0 != '0) ? last.idx - gsni_pkg::IDX_W'(1) : '0;
        n_out_xp = (last.px0 != r_size_x - gsni_pkg::SIZE_W'(1)) ?
                   last.idx + gsni_pkg::IDX_W'(1) : '0;
        n_out_ym = (py0 != '0) ? last.idx - sx : '0;
        n_out_yp = (py0 != r_size_y - gsni_pkg::SIZE_W'(1)) ? last.idx + sx : '0;
        n_out_zm = (pz0 != '0) ? last.idx - sxy : '0;
        n_out_zp = (pz0 < gsni_pkg::DQ_W'(r_size_z) - gsni_pkg::DQ_W'(1)) ?
                   last.idx + sxy : '0;
        if (last.err) begin
            n_out_xm = '0;
            n_out_xp = '0;
            n_out_ym = '0;
            n_out_yp = '0;
            n_out_zm = '0;
            n_out_zp = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_vld[gsni_pkg::NUM_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_err <= r_stg[gsni_pkg::NUM_STAGES].err;
        r_out_xm  <= n_out_xm;
        r_out_xp  <= n_out_xp;
        r_out_ym  <= n_out_ym;
        r_out_yp  <= n_out_yp;
        r_out_zm  <= n_out_zm;
        r_out_zp  <= n_out_zp;
    end

    assign o_valid             = r_out_valid;
    assign o_index_error       = r_out_err;
    assign o_neighbour_x_minus = r_out_xm;
    assign o_neighbour_x_plus  = r_out_xp;
    assign o_neighbour_y_minus = r_out_ym;
    assign o_neighbour_y_plus  = r_out_yp;
    assign o_neighbour_z_minus = r_out_zm;
    assign o_neighbour_z_plus  = r_out_zp;

endmodule

>>> src/gsni_checker.sv
`include "grid_six_neighbour_index_unit_assert.svh"

module gsni_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       o_valid,
    input logic [gsni_pkg::IDX_W-1:0] o_neighbour_x_minus,
    input logic [gsni_pkg::IDX_W-1:0] o_neighbour_x_plus,
    input logic [gsni_pkg::IDX_W-1:0] o_neighbour_y_minus,
    input logic [gsni_pkg::IDX_W-1:0] o_neighbour_y_plus,
    input logic [gsni_pkg::IDX_W-1:0] o_neighbour_z_minus,
    input logic [gsni_pkg::IDX_W-1:0] o_neighbour_z_plus,
    input logic                       o_index_error
);

    // every request comes out exactly once, after a fixed latency
    `GSNI_ASSERT_ALWAYS(a_fixed_latency, o_valid == $past(start && !busy, gsni_pkg::PIPE_LAT), "result strobe does not match request latency")

    `GSNI_ASSERT_IMPL(a_err_zero, o_valid && o_index_error, (o_neighbour_x_minus == '0) && (o_neighbour_x_plus == '0) && (o_neighbour_y_minus == '0) && (o_neighbour_y_plus == '0) && (o_neighbour_z_minus == '0) && (o_neighbour_z_plus == '0), "error result has a nonzero neighbour")

    `GSNI_ASSERT_IMPL(a_x_pair, o_valid && (o_neighbour_x_minus != '0) && (o_neighbour_x_plus != '0), o_neighbour_x_plus == o_neighbour_x_minus + gsni_pkg::IDX_W'(2), "x neighbours not two apart")

    // both pairs sit symmetric around the same point, modulo the index width
    `GSNI_ASSERT_IMPL(a_y_center, o_valid && (o_neighbour_x_minus != '0) && (o_neighbour_x_plus != '0) && (o_neighbour_y_minus != '0) && (o_neighbour_y_plus != '0), gsni_pkg::IDX_W'(o_neighbour_y_minus + o_neighbour_y_plus) == gsni_pkg::IDX_W'(o_neighbour_x_minus + o_neighbour_x_plus), "y neighbours not centered on the request")

endmodule

bind grid_six_neighbour_index_unit gsni_checker u_gsni_checker (.*);

>>> tb/tb_grid_six_neighbour_index_unit.sv
module tb_grid_six_neighbour_index_unit;
    import gsni_pkg::*;

    typedef struct packed {
        logic [5:0][IDX_W-1:0] nb;
        logic                  err;
    } t_neighbour_set;

    class stencil_check;
        logic [SIZE_W-1:0] dim_x = 1;
        logic [SIZE_W-1:0] dim_y = 1;
        logic [SIZE_W-1:0] dim_z = 1;
        logic [IDX_W-1:0]  last_index = 1;
        t_neighbour_set    expected_sets [$];
        int                mismatches = 0;
        string             field_names [6] = '{"x_minus", "x_plus", "y_minus",
                                               "y_plus", "z_minus", "z_plus"};

        function void set_reg(input logic [CFG_IDX_W-1:0] ri, input logic [IDX_W-1:0] d);
            case (ri)
                CFG_SIZE_X:      dim_x = d[SIZE_W-1:0];
                CFG_SIZE_Y:      dim_y = d[SIZE_W-1:0];
                CFG_SIZE_Z:      dim_z = d[SIZE_W-1:0];
                CFG_POINT_COUNT: last_index = d;
                default: ;
            endcase
        endfunction

        static function longint unsigned clamp_dim(input logic [SIZE_W-1:0] s);
            if (s == 0) return 1;
            if (s > MAX_DIM) return MAX_DIM;
            return s;
        endfunction

        function t_neighbour_set neighbours_of(input logic [IDX_W-1:0] idx);
            t_neighbour_set  r;
            longint unsigned sx, sy, sz, sxy, p, k, px, py, pz;
            r   = '0;
            sx  = clamp_dim(dim_x);
            sy  = clamp_dim(dim_y);
            sz  = clamp_dim(dim_z);
            sxy = sx * sy;
            p   = idx;
            if (p == 0 || p > last_index) begin
                r.err = 1'b1;
                return r;
            end
            k  = p - 1;
            px = k % sx + 1;
            py = (k % sxy) / sx + 1;
            pz = k / sxy + 1;
            if (px > 1)  r.nb[0] = IDX_W'(p - 1);
            if (px < sx) r.nb[1] = IDX_W'(p + 1);
            if (py > 1)  r.nb[2] = IDX_W'(p - sx);
            if (py < sy) r.nb[3] = IDX_W'(p + sx);
            if (pz > 1)  r.nb[4] = IDX_W'(p - sxy);
            if (pz < sz) r.nb[5] = IDX_W'(p + sxy);
            return r;
        endfunction

        function void note_point(input logic [IDX_W-1:0] idx);
            expected_sets.push_back(neighbours_of(idx));
        endfunction

        function int pending();
            return expected_sets.size();
        endfunction

        function void flag(input string what, input longint unsigned want,
                           input longint unsigned got);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %0h got %0h", what, want, got);
        endfunction

        function void check_neighbours(input t_neighbour_set got);
            t_neighbour_set want;
            if (expected_sets.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: err %0b x_minus %0h", got.err, got.nb[0]);
                return;
            end
            want = expected_sets.pop_front();
            for (int i = 0; i < 6; i++) begin
                if (got.nb[i] !== want.nb[i])
                    flag(field_names[i], want.nb[i], got.nb[i]);
            end
            if (got.err !== want.err)
                flag("index_error", want.err, got.err);
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic [IDX_W-1:0]     i_point_index;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [IDX_W-1:0]     i_cfg_data;
    logic                 o_valid;
    logic [IDX_W-1:0]     o_neighbour_x_minus;
    logic [IDX_W-1:0]     o_neighbour_x_plus;
    logic [IDX_W-1:0]     o_neighbour_y_minus;
    logic [IDX_W-1:0]     o_neighbour_y_plus;
    logic [IDX_W-1:0]     o_neighbour_z_minus;
    logic [IDX_W-1:0]     o_neighbour_z_plus;
    logic                 o_index_error;
    t_neighbour_set       dut_result;

    stencil_check sb;

    grid_six_neighbour_index_unit u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_point_index       (i_point_index),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data),
        .o_valid             (o_valid),
        .o_neighbour_x_minus (o_neighbour_x_minus),
        .o_neighbour_x_plus  (o_neighbour_x_plus),
        .o_neighbour_y_minus (o_neighbour_y_minus),
        .o_neighbour_y_plus  (o_neighbour_y_plus),
        .o_neighbour_z_minus (o_neighbour_z_minus),
        .o_neighbour_z_plus  (o_neighbour_z_plus),
        .o_index_error       (o_index_error)
    );

    assign dut_result = {o_neighbour_z_plus, o_neighbour_z_minus, o_neighbour_y_plus,
                         o_neighbour_y_minus, o_neighbour_x_plus, o_neighbour_x_minus,
                         o_index_error};

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

    // accepted requests and results, both sampled at the edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy)
                sb.note_point(i_point_index);
            if (o_valid)
                sb.check_neighbours(dut_result);
        end
    end

    task automatic send_point(input logic [IDX_W-1:0] v, input int idle_pct);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_point_index <= v;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic send_list(input logic [IDX_W-1:0] pts [$]);
        foreach (pts[i])
            send_point(pts[i], 0);
    endtask

    // first wait for a clock edge so the last accepted request is already noted
    task automatic wait_until_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    task automatic configure(input logic [IDX_W-1:0] dx, input logic [IDX_W-1:0] dy,
                             input logic [IDX_W-1:0] dz, input logic [IDX_W-1:0] pc);
        logic [IDX_W-1:0]     vals [4];
        logic [CFG_IDX_W-1:0] regs [4];
        vals = '{dx, dy, dz, pc};
        regs = '{CFG_SIZE_X, CFG_SIZE_Y, CFG_SIZE_Z, CFG_POINT_COUNT};
        for (int i = 0; i < 4; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= regs[i];
            i_cfg_data <= vals[i];
            @(posedge i_clk);
            sb.set_reg(regs[i], vals[i]);
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [IDX_W-1:0] pick_dim();
        logic [IDX_W-1:0] d;
        d = IDX_W'($urandom);
        if ($urandom_range(1) == 0)
            d[IDX_W-1:SIZE_W] = '0;
        case ($urandom_range(9))
            0:       d[SIZE_W-1:0] = '0;
            1:       d[SIZE_W-1:0] = SIZE_W'($urandom_range(1025, 2047));
            2:       d[SIZE_W-1:0] = SIZE_W'(MAX_DIM);
            3:       d[SIZE_W-1:0] = SIZE_W'(1);
            default: d[SIZE_W-1:0] = SIZE_W'($urandom_range(2, 12));
        endcase
        return d;
    endfunction

    function automatic logic [IDX_W-1:0] random_point(input logic [IDX_W-1:0] pc,
                                                       input longint unsigned grid);
        longint unsigned top;
        top = (grid < pc) ? grid : pc;
        case ($urandom_range(19))
            0:       return '0;
            1:       return pc;
            2:       return pc + 1'b1;
            3, 4:    return IDX_W'($urandom);
            5, 6:    return IDX_W'($urandom_range(1, 32'(pc)));
            default: return IDX_W'($urandom_range(1, 32'(top)));
        endcase
    endfunction

    initial begin
        int               idle_pct [8];
        logic [IDX_W-1:0] dx, dy, dz, pc;
        longint unsigned  grid;

        idle_pct = '{0, 67, 0, 29, 67, 29, 0, 67};
        sb = new();
        start         <= 1'b0;
        i_point_index <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_SIZE_X;
        i_cfg_data    <= '0;
        i_rst_n       <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do @(posedge i_clk); while (busy);

        // reset sizes: a single point
        send_list('{31'd1, 31'd0, 31'd2});
        wait_until_drained();

        configure(31'd4, 31'd3, 31'd2, 31'd24);
        send_list('{31'd1, 31'd4, 31'd5, 31'd12, 31'd13, 31'd24, 31'd25, 31'd18, 31'd7,
                    31'h7FFF_FFFF});
        wait_until_drained();

        // zero size, oversize registers, index past the last z layer
        configure(31'h7FFF_F800, 31'h7FFF_FFFF, 31'd1025, 31'h7FFF_FFFF);
        send_list('{31'd1, 31'd1024, 31'd1025, 31'h0010_0000, 31'h0010_0001,
                    31'h4000_0000, 31'h7FFF_FFFF});
        wait_until_drained();

        configure(31'd1024, 31'd1024, 31'd1024, 31'h4000_0000);
        send_list('{31'd1, 31'h4000_0000, 31'h4000_0001, 31'h3FF0_0001});
        wait_until_drained();

        for (int ph = 0; ph < 8; ph++) begin
            dx   = pick_dim();
            dy   = pick_dim();
            dz   = pick_dim();
            grid = stencil_check::clamp_dim(dx[SIZE_W-1:0])
                 * stencil_check::clamp_dim(dy[SIZE_W-1:0])
                 * stencil_check::clamp_dim(dz[SIZE_W-1:0]);
            case ($urandom_range(7))
                0:       pc = IDX_W'($urandom);
                1:       pc = 31'd1;
                2:       pc = 31'h7FFF_FFFF;
                3:       pc = IDX_W'(grid + $urandom_range(0, 40));
                default: pc = IDX_W'(grid);
            endcase
            configure(dx, dy, dz, pc);
            for (int n = 0; n < 119; n++)
                send_point(random_point(pc, grid), ((n / 16) % 3 == 0) ? 0 : idle_pct[ph]);
            wait_until_drained();
        end

        repeat (PIPE_LAT + 4) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
